@@ sv/pidgd_pkg.sv @@
// pidgd_pkg: types and fixed constants for the positional pid with gyro damping
`timescale 1ns / 1ps
package pidgd_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SQ,
    S_LOAD,
    S_MUL,
    S_SAT,
    S_SMOOTH,
    S_DONE
  } state_t;

  localparam int GAIN_W  = 16;
  localparam int FACT_W  = 8;
  localparam int INTEG_W = 32;
  localparam int SQ_BITS = 24;
  localparam int OP_W    = 48;
  localparam int ACC_W   = GAIN_W + OP_W + 3;
  localparam int CNT_W   = 5;
  localparam int TERM_W  = 3;

  localparam logic [46:0] SQ_CAP    = 47'(64'd1 << 46);
  localparam logic [33:0] SQ_LIMIT  = 34'(64'd1 << 23);
  localparam logic [4:0]  LIMIT_DIV = 5'd9;

  localparam logic [TERM_W-1:0] TERM_PROP  = 3'd0;
  localparam logic [TERM_W-1:0] TERM_SQ    = 3'd1;
  localparam logic [TERM_W-1:0] TERM_INTEG = 3'd2;
  localparam logic [TERM_W-1:0] TERM_DERIV = 3'd3;
  localparam logic [TERM_W-1:0] TERM_GYRO  = 3'd4;

  localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [2:0] REG_GAIN_SQ     = 3'd1;
  localparam logic [2:0] REG_GAIN_INTEG  = 3'd2;
  localparam logic [2:0] REG_GAIN_DERIV  = 3'd3;
  localparam logic [2:0] REG_GAIN_GYRO   = 3'd4;
  localparam logic [2:0] REG_DRIVE_MAX   = 3'd5;
  localparam logic [2:0] REG_DRIVE_MIN   = 3'd6;
  localparam logic [2:0] REG_SMOOTH      = 3'd7;

endpackage

@@ sv/positional_pid_with_gyro_damping.sv @@
// positional pid controller with gyro damping, bit-serial datapath
//
// usage: one input transfer on s_* carries measured, gyro_rate and target;
// one output transfer on m_* carries the drive. the cfg_* channel writes the
// gains, drive limits and smoothing factor by register index; write it only
// while the block is idle. cfg_ready is always high.
// per item a sequencer runs a bit-serial division by 9 for the integral
// limits, then one shared shift-add unit that takes one multiplier bit per
// cycle for the error square and for the gain products of 5 terms, each
// product after a load step; then a saturation step, a smoothing product
// when smoothing is on, and the load of the output register. the block
// returns to idle after each item and takes no new item before that.
// a new item is accepted while the previous drive still waits in the output
// register; the finished drive then waits until that register is free.
// reset clears the registers to their defaults, the previous error, the
// integral and the previous drive.
`timescale 1ns / 1ps
module positional_pid_with_gyro_damping import pidgd_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int GAIN_FRAC_BITS = 8,
  localparam int IN_W = ((3 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int CFG_W = (DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // measured, gyro_rate, target
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // drive
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int DW = DATA_WIDTH;

  state_t state, state_next;

  logic signed [GAIN_W-1:0] gain_prop, gain_sq, gain_integ, gain_deriv, gain_gyro;
  logic signed [DW-1:0]     drive_max, drive_min;
  logic [FACT_W-1:0]        smooth_factor;
  logic signed [DW:0]       prev_error;
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [DW-1:0]     prev_drive;
  logic [DW-1:0]            drive_out;

  logic signed [DW:0]       err_r;
  logic signed [DW+1:0]     diff_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [DW-1:0]     gyro_r;
  logic                     sq_neg, sq_cap;
  logic [SQ_BITS-1:0]       am_r;
  logic signed [OP_W-1:0]   sq_s;
  logic signed [DW-1:0]     imax, imin;
  logic [DW-1:0]            dsr, qsr;
  logic [3:0]               rem;
  logic                     div_sel;
  logic [CNT_W-1:0]         cnt;
  logic [TERM_W-1:0]        term;
  logic signed [ACC_W-1:0]  mcand, acc;
  logic [SQ_BITS-1:0]       mplier;
  logic signed [DW-1:0]     sat_r, res_r;

  // input decode
  logic signed [DW-1:0]      meas_in, gyro_in, tgt_in;
  logic signed [DW:0]        err_in;
  logic signed [DW+1:0]      diff_in;
  logic signed [INTEG_W:0]   integ_wide;
  logic signed [INTEG_W-1:0] integ_in;
  logic [DW:0]               am_full;
  logic [33:0]               am_ext;

  assign meas_in = s_tdata[DW-1:0];
  assign gyro_in = s_tdata[2*DW-1:DW];
  assign tgt_in  = s_tdata[3*DW-1:2*DW];

  always_comb begin
    err_in     = {tgt_in[DW-1], tgt_in} - {meas_in[DW-1], meas_in};
    diff_in    = {err_in[DW], err_in} - {prev_error[DW], prev_error};
    integ_wide = {integral_sum[INTEG_W-1], integral_sum} + (INTEG_W+1)'(err_in);
    if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
      integ_in = integ_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_in = integ_wide[INTEG_W-1:0];
    end
    am_full = err_in[DW] ? (DW+1)'(-err_in) : err_in;
    am_ext  = 34'(am_full);
  end

  // bit-serial division by 9 of a limit magnitude
  logic [4:0]           trial;
  logic                 qbit;
  logic [3:0]           rem_next;
  logic [DW-1:0]        qsr_next;
  logic signed [DW-1:0] quo;
  logic                 div_neg;
  logic [DW-1:0]        min_mag, max_mag;

  always_comb begin
    trial    = {rem, dsr[DW-1]};
    qbit     = (trial >= LIMIT_DIV);
    rem_next = qbit ? 4'(trial - LIMIT_DIV) : trial[3:0];
    qsr_next = {qsr[DW-2:0], qbit};
    div_neg  = div_sel ? drive_min[DW-1] : drive_max[DW-1];
    quo      = div_neg ? DW'(-qsr_next) : qsr_next;
    max_mag  = drive_max[DW-1] ? DW'(-drive_max) : drive_max;
    min_mag  = drive_min[DW-1] ? DW'(-drive_min) : drive_min;
  end

  // shared shift-add unit
  logic                    step_en, sub;
  logic signed [ACC_W-1:0] addend, acc_next;

  always_comb begin
    if (mplier[0]) begin
      addend = sub ? -mcand : mcand;
    end else begin
      addend = '0;
    end
    acc_next = step_en ? acc + addend : acc;
  end

  // square result
  logic [46:0]            sq_val;
  logic signed [OP_W-1:0] sq_next;

  always_comb begin
    sq_val  = sq_cap ? SQ_CAP : acc_next[46:0];
    sq_next = sq_neg ? -{1'b0, sq_val} : {1'b0, sq_val};
  end

  // term operand and gain
  logic signed [ACC_W-1:0]  op_sel;
  logic signed [GAIN_W-1:0] gain_sel;

  always_comb begin
    case (term)
      TERM_PROP:  begin op_sel = ACC_W'(err_r);   gain_sel = gain_prop;  end
      TERM_SQ:    begin op_sel = ACC_W'(sq_s);    gain_sel = gain_sq;    end
      TERM_INTEG: begin op_sel = ACC_W'(integ_r); gain_sel = gain_integ; end
      TERM_DERIV: begin op_sel = ACC_W'(diff_r);  gain_sel = gain_deriv; end
      default:    begin op_sel = ACC_W'(gyro_r);  gain_sel = gain_gyro;  end
    endcase
  end

  // saturation, integral clamp, smoothing
  logic signed [ACC_W-1:0]   sum_sh;
  logic signed [DW-1:0]      sat_val;
  logic signed [INTEG_W:0]   integ_x, imax_x, imin_x;
  logic signed [INTEG_W-1:0] integ_clamp;
  logic signed [DW:0]        smooth_d;
  logic signed [ACC_W-1:0]   smooth_sh;
  logic signed [DW-1:0]      res_val;

  always_comb begin
    sum_sh = acc >>> GAIN_FRAC_BITS;
    if (sum_sh > ACC_W'(drive_max)) begin
      sat_val = drive_max;
    end else if (sum_sh < ACC_W'(drive_min)) begin
      sat_val = drive_min;
    end else begin
      sat_val = sum_sh[DW-1:0];
    end
    integ_x = (INTEG_W+1)'(integ_r);
    imax_x  = (INTEG_W+1)'(imax);
    imin_x  = (INTEG_W+1)'(imin);
    if (integ_x > imax_x) begin
      integ_clamp = INTEG_W'(imax);
    end else if (integ_x < imin_x) begin
      integ_clamp = INTEG_W'(imin);
    end else begin
      integ_clamp = integ_r;
    end
    smooth_d  = {prev_drive[DW-1], prev_drive} - {sat_val[DW-1], sat_val};
    smooth_sh = acc_next >>> FACT_W;
    res_val   = sat_r + smooth_sh[DW-1:0];
  end

  logic out_load;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_DIV;
      S_DIV:    if (cnt == CNT_W'(DW - 1) && div_sel) state_next = S_SQ;
      S_SQ:     if (cnt == CNT_W'(SQ_BITS - 1)) state_next = S_LOAD;
      S_LOAD:   state_next = S_MUL;
      S_MUL: begin
        if (cnt == CNT_W'(GAIN_W - 1)) begin
          state_next = (term == TERM_GYRO) ? S_SAT : S_LOAD;
        end
      end
      S_SAT:    state_next = (smooth_factor == '0) ? S_DONE : S_SMOOTH;
      S_SMOOTH: if (cnt == CNT_W'(FACT_W - 1)) state_next = S_DONE;
      S_DONE:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = (state == S_IDLE);
    cfg_ready = 1'b1;
    step_en  = (state == S_SQ) || (state == S_MUL) || (state == S_SMOOTH);
    sub      = (state == S_MUL) && (cnt == CNT_W'(GAIN_W - 1));
    out_load = (state == S_DONE) && (!m_tvalid || m_tready);
  end

  assign m_tdata = OUT_W'(drive_out);

  // control state, registers and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      gain_prop     <= '0;
      gain_sq       <= '0;
      gain_integ    <= '0;
      gain_deriv    <= '0;
      gain_gyro     <= '0;
      drive_max     <= {1'b0, {(DW-1){1'b1}}};
      drive_min     <= {1'b1, {(DW-1){1'b0}}};
      smooth_factor <= '0;
      prev_error    <= '0;
      integral_sum  <= '0;
      prev_drive    <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GAIN_PROP:  gain_prop     <= cfg_data[GAIN_W-1:0];
          REG_GAIN_SQ:    gain_sq       <= cfg_data[GAIN_W-1:0];
          REG_GAIN_INTEG: gain_integ    <= cfg_data[GAIN_W-1:0];
          REG_GAIN_DERIV: gain_deriv    <= cfg_data[GAIN_W-1:0];
          REG_GAIN_GYRO:  gain_gyro     <= cfg_data[GAIN_W-1:0];
          REG_DRIVE_MAX:  drive_max     <= cfg_data[DW-1:0];
          REG_DRIVE_MIN:  drive_min     <= cfg_data[DW-1:0];
          REG_SMOOTH:     smooth_factor <= cfg_data[FACT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        prev_error <= err_in;
      end
      if (state == S_SAT) begin
        integral_sum <= integ_clamp;
      end
      if (out_load) begin
        m_tvalid   <= 1'b1;
        prev_drive <= res_r;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        err_r   <= err_in;
        diff_r  <= diff_in;
        integ_r <= integ_in;
        gyro_r  <= gyro_in;
        sq_neg  <= err_in[DW];
        sq_cap  <= (am_ext > SQ_LIMIT);
        am_r    <= am_ext[SQ_BITS-1:0];
        dsr     <= max_mag;
        rem     <= '0;
        qsr     <= '0;
        div_sel <= 1'b0;
        cnt     <= '0;
      end
      S_DIV: begin
        if (cnt == CNT_W'(DW - 1)) begin
          cnt <= '0;
          if (!div_sel) begin
            imax    <= quo;
            div_sel <= 1'b1;
            dsr     <= min_mag;
            rem     <= '0;
            qsr     <= '0;
          end else begin
            imin   <= quo;
            mcand  <= ACC_W'(am_r);
            mplier <= am_r;
            acc    <= '0;
          end
        end else begin
          dsr <= dsr << 1;
          rem <= rem_next;
          qsr <= qsr_next;
          cnt <= cnt + 1'b1;
        end
      end
      S_SQ: begin
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_W'(SQ_BITS - 1)) begin
          sq_s <= sq_next;
          acc  <= '0;
          term <= TERM_PROP;
        end else begin
          acc <= acc_next;
        end
      end
      S_LOAD: begin
        mcand  <= op_sel;
        mplier <= SQ_BITS'($unsigned(gain_sel));
        cnt    <= '0;
      end
      S_MUL: begin
        acc    <= acc_next;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_W'(GAIN_W - 1)) begin
          term <= term + 1'b1;
        end
      end
      S_SAT: begin
        sat_r  <= sat_val;
        res_r  <= sat_val;
        mcand  <= ACC_W'(smooth_d);
        mplier <= SQ_BITS'(smooth_factor);
        acc    <= '0;
        cnt    <= '0;
      end
      S_SMOOTH: begin
        acc    <= acc_next;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_W'(FACT_W - 1)) begin
          res_r <= res_val;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          drive_out <= res_r;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // an accepted item always starts with the limit division
  a_accept_div: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_DIV)
    else $error("accepted item did not start division");

  // the sign bit of a gain ends each product
  a_mul_end: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL && cnt == CNT_W'(GAIN_W - 1) |=> state == S_LOAD || state == S_SAT)
    else $error("product did not end after the gain sign bit");

  // a finished drive with a free output register shows up next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !m_tvalid |=> m_tvalid && state == S_IDLE)
    else $error("finished drive not presented");
`endif

endmodule

@@ sim/positional_pid_with_gyro_damping_tb.sv @@
// testbench for the positional pid controller with gyro damping
`timescale 1ns / 1ps
module positional_pid_with_gyro_damping_tb import pidgd_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // measured, gyro_rate, target
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // drive
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  positional_pid_with_gyro_damping DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // controller copy: registers and loop state
  logic signed [15:0] kp, ksq, ki, kd, kg, lim_hi, lim_lo;
  logic [7:0]         blend;
  logic signed [63:0] last_err, integ_acc, last_drive;

  logic [15:0] drive_q[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_recv = 1'b0;
  longint      cycles = 0;

  function automatic logic signed [63:0] floor_div256(logic signed [63:0] v);
    return v >>> 8;
  endfunction

  function automatic logic [15:0] next_drive(logic signed [15:0] meas,
                                             logic signed [15:0] gyro,
                                             logic signed [15:0] tgt);
    logic signed [63:0] e, d, ig, sq, sum, sat, res, ihi, ilo, am;
    e   = 64'(tgt) - 64'(meas);
    d   = e - last_err;
    ig  = integ_acc + e;
    ihi = 64'(lim_hi) / 9;
    ilo = 64'(lim_lo) / 9;
    if (ig > 64'sd2147483647) ig = 64'sd2147483647;
    if (ig < -64'sd2147483648) ig = -64'sd2147483648;
    am = (e < 0) ? -e : e;
    sq = am * am;
    if (e < 0) sq = -sq;
    sum = 64'(kp) * e + 64'(ksq) * sq + 64'(ki) * ig + 64'(kd) * d
        + 64'(kg) * 64'(gyro);
    sum = floor_div256(sum);
    last_err = e;
    if (ig > ihi) ig = ihi;
    else if (ig < ilo) ig = ilo;
    integ_acc = ig;
    if (sum > 64'(lim_hi)) sat = 64'(lim_hi);
    else if (sum < 64'(lim_lo)) sat = 64'(lim_lo);
    else sat = sum;
    if (blend != 0)
      res = floor_div256(last_drive * 64'(blend) + sat * (256 - 64'(blend)));
    else
      res = sat;
    last_drive = res;
    return res[15:0];
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (drive_q.size() == 0) begin
          $error("drive: unexpected transfer, actual %0d", $signed(m_tdata));
          errors++;
        end else begin
          if (m_tdata !== drive_q[0]) begin
            $error("drive: expected %0d actual %0d", $signed(drive_q[0]),
                   $signed(m_tdata));
            errors++;
          end
          void'(drive_q.pop_front());
        end
      end
      m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(logic signed [15:0] meas, logic signed [15:0] gyro,
                           logic signed [15:0] tgt);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {tgt, gyro, meas};
    drive_q.push_back(next_drive(meas, gyro, tgt));
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (drive_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GAIN_PROP:  kp = val;
      REG_GAIN_SQ:    ksq = val;
      REG_GAIN_INTEG: ki = val;
      REG_GAIN_DERIV: kd = val;
      REG_GAIN_GYRO:  kg = val;
      REG_DRIVE_MAX:  lim_hi = val;
      REG_DRIVE_MIN:  lim_lo = val;
      REG_SMOOTH:     blend = val[7:0];
      default: ;
    endcase
  endtask

  // registers change only once every transfer in flight has come out
  task automatic set_all(logic [15:0] p, logic [15:0] q, logic [15:0] i,
                         logic [15:0] d, logic [15:0] g, logic [15:0] hi,
                         logic [15:0] lo, logic [7:0] f);
    drain();
    write_reg(REG_GAIN_PROP, p);
    write_reg(REG_GAIN_SQ, q);
    write_reg(REG_GAIN_INTEG, i);
    write_reg(REG_GAIN_DERIV, d);
    write_reg(REG_GAIN_GYRO, g);
    write_reg(REG_DRIVE_MAX, hi);
    write_reg(REG_DRIVE_MIN, lo);
    write_reg(REG_SMOOTH, {8'd0, f});
  endtask

  task automatic test_directed();
    send_item(16'sd0, 16'sd0, 16'sd0);
    set_all(16'h0100, 16'h0001, 16'h0040, 16'h0080, 16'h0100, 16'sd30000,
            -16'sd30000, 8'd0);
    send_item(-16'sd32768, 16'sd32767, 16'sd32767);
    send_item(16'sd32767, -16'sd32768, -16'sd32768);
    send_item(16'sd100, 16'sd5, 16'sd120);
    send_item(16'sd100, -16'sd5, 16'sd80);
    drain();
    // extreme gains with inverted limits
    set_all(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, -16'sd100,
            16'sd100, 8'd255);
    send_item(16'sd0, 16'sd1, 16'sd1);
    send_item(16'sd32767, 16'sd0, -16'sd32768);
    send_item(-16'sd32768, 16'sd0, 16'sd32767);
    send_item(16'sd5, 16'sd32767, 16'sd5);
    drain();
    set_all(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'sd32767,
            -16'sd32768, 8'd1);
    send_item(16'sd1, -16'sd1, -16'sd1);
    send_item(-16'sd32768, -16'sd32768, 16'sd32767);
    send_item(16'sd32767, 16'sd32767, -16'sd32768);
    // integral limit: unit integral gain only, long same-sign error
    set_all(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'sd32767,
            -16'sd32768, 8'd128);
    repeat (6) send_item(-16'sd32768, 16'sd0, 16'sd32767);
    drain();
  endtask

  task automatic random_phase(int n);
    logic signed [15:0] base;
    drain();
    set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom),
            ($urandom_range(3) == 0) ? 16'($urandom)
                                     : 16'(16'sd32767 - $urandom_range(4000)),
            ($urandom_range(3) == 0) ? 16'($urandom)
                                     : 16'(-16'sd32768 + $urandom_range(4000)),
            ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom));
    base = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(3) == 0)
        send_item(16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_item(base + 16'($signed($urandom_range(400)) - 200),
                  16'($signed($urandom_range(2000)) - 1000), base);
    end
  endtask

  task automatic test_stall_and_pause();
    hold_recv = 1'b1;
    fork
      begin
        for (int k = 0; k < 6; k++)
          send_item(16'($urandom), 16'($urandom), 16'($urandom));
      end
      begin
        repeat (1500) @(posedge clk);
        hold_recv = 1'b0;
      end
    join
    drain();
    for (int k = 0; k < 4; k++)
      send_item(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    kp = 0; ksq = 0; ki = 0; kd = 0; kg = 0;
    lim_hi = 16'sd32767; lim_lo = -16'sd32768; blend = 0;
    last_err = 0; integ_acc = 0; last_drive = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle = 22; recv_idle = 71;
    for (int p = 0; p < 4; p++) random_phase(50);
    send_idle = 71; recv_idle = 22;
    for (int p = 0; p < 4; p++) random_phase(50);
    send_idle = 0; recv_idle = 0;
    for (int p = 0; p < 4; p++) random_phase(50);
    test_stall_and_pause();
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
